// File: sv/rlmax_pkg.sv
`default_nettype none
package rlmax_pkg;

  localparam int unsigned VW = 63;

  typedef logic [VW-1:0] val_t;

  localparam val_t ONES = {VW{1'b1}};

  typedef enum logic [1:0] {
    ACT_UPDATE = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_QUERY  = 2'd2
  } action_t;

  // One tree node as held in the node store.
  typedef struct packed {
    val_t pend;
    val_t uor;
    val_t andv;
  } node_t;

  // How the current frame of the walk relates to the requested range, or that it is a pull frame.
  typedef enum logic [1:0] {
    CLS_DISJ,
    CLS_COV,
    CLS_PART,
    CLS_PULL
  } cls_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DECIDE, ST_POP, ST_EXAM, ST_COV, ST_PART_O,
    ST_PD_A, ST_PD_B, ST_PUSH_P, ST_PUSH_R, ST_PUSH_L, ST_PULL_A, ST_PULL_B,
    ST_BF_INIT, ST_BF_LOAD, ST_BF_TEST, ST_BF_O, ST_BF_A, ST_BF_B, ST_EMIT
  } st_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_DECIDE, OP_POP, OP_EXAM, OP_COV, OP_PART_O,
    OP_PD_A, OP_PD_B, OP_PUSH_P, OP_PUSH_R, OP_PUSH_L, OP_PULL_A, OP_PULL_B,
    OP_BF_INIT, OP_BF_LOAD, OP_BF_TEST, OP_BF_O, OP_BF_A, OP_BF_B, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic in_fire;
    logic is_query;
    logic start_walk;
    logic emit_bad;
    logic stack_empty;
    cls_t cls;
    logic cur_leaf;
    logic k_zero;
    logic out_free;
  } sts_t;

  // AND a mask into a node; a leaf keeps an all-ones leave-one-out OR.
  function automatic node_t apply_and(node_t n, logic leaf, val_t m);
    node_t res;
    res.andv = n.andv & m;
    res.pend = n.pend & m;
    res.uor  = leaf ? ONES : (n.uor & m);
    return res;
  endfunction

  // Rebuild a parent from its two children.
  function automatic node_t pull_node(node_t a, node_t b);
    node_t res;
    res.andv = a.andv & b.andv;
    res.uor  = (a.andv & b.uor) | (a.uor & b.andv);
    res.pend = ONES;
    return res;
  endfunction

endpackage
`default_nettype wire

// File: sv/rlmax_ctrl.sv
`default_nettype none
module rlmax_ctrl
  import rlmax_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  sts_t sts,
  output cmd_t cmd
);

  st_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:   if (sts.clear_done) state_nxt = ST_IDLE;
      ST_IDLE:    if (sts.in_fire) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (sts.start_walk)    state_nxt = ST_POP;
        else if (sts.emit_bad) state_nxt = ST_EMIT;
        else                   state_nxt = ST_IDLE;
      end
      ST_POP: begin
        if (!sts.stack_empty)  state_nxt = ST_EXAM;
        else if (sts.is_query) state_nxt = ST_BF_INIT;
        else                   state_nxt = ST_IDLE;
      end
      ST_EXAM: begin
        case (sts.cls)
          CLS_DISJ: state_nxt = ST_POP;
          CLS_COV:  state_nxt = ST_COV;
          CLS_PULL: state_nxt = ST_PULL_A;
          default:  state_nxt = ST_PART_O;
        endcase
      end
      ST_COV:     state_nxt = ST_POP;
      ST_PART_O:  state_nxt = sts.is_query ? ST_PUSH_R : ST_PD_A;
      ST_PD_A:    state_nxt = ST_PD_B;
      ST_PD_B:    state_nxt = ST_PUSH_P;
      ST_PUSH_P:  state_nxt = ST_PUSH_R;
      ST_PUSH_R:  state_nxt = ST_PUSH_L;
      ST_PUSH_L:  state_nxt = ST_POP;
      ST_PULL_A:  state_nxt = ST_PULL_B;
      ST_PULL_B:  state_nxt = ST_POP;
      ST_BF_INIT: state_nxt = ST_BF_LOAD;
      ST_BF_LOAD: state_nxt = ST_BF_TEST;
      ST_BF_TEST: begin
        if (!sts.cur_leaf)   state_nxt = ST_BF_O;
        else if (sts.k_zero) state_nxt = ST_EMIT;
        else                 state_nxt = ST_BF_LOAD;
      end
      ST_BF_O:    state_nxt = ST_BF_A;
      ST_BF_A:    state_nxt = ST_BF_B;
      ST_BF_B:    state_nxt = ST_BF_TEST;
      ST_EMIT:    if (sts.out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd.in_ready = 1'b0;
    cmd.op       = OP_NONE;
    case (state_r)
      ST_CLEAR:   cmd.op = OP_CLEAR;
      ST_IDLE:    cmd.in_ready = 1'b1;
      ST_DECIDE:  cmd.op = OP_DECIDE;
      ST_POP:     cmd.op = OP_POP;
      ST_EXAM:    cmd.op = OP_EXAM;
      ST_COV:     cmd.op = OP_COV;
      ST_PART_O:  cmd.op = OP_PART_O;
      ST_PD_A:    cmd.op = OP_PD_A;
      ST_PD_B:    cmd.op = OP_PD_B;
      ST_PUSH_P:  cmd.op = OP_PUSH_P;
      ST_PUSH_R:  cmd.op = OP_PUSH_R;
      ST_PUSH_L:  cmd.op = OP_PUSH_L;
      ST_PULL_A:  cmd.op = OP_PULL_A;
      ST_PULL_B:  cmd.op = OP_PULL_B;
      ST_BF_INIT: cmd.op = OP_BF_INIT;
      ST_BF_LOAD: cmd.op = OP_BF_LOAD;
      ST_BF_TEST: cmd.op = OP_BF_TEST;
      ST_BF_O:    cmd.op = OP_BF_O;
      ST_BF_A:    cmd.op = OP_BF_A;
      ST_BF_B:    cmd.op = OP_BF_B;
      ST_EMIT:    cmd.op = sts.out_free ? OP_EMIT : OP_NONE;
      default:    cmd.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/rlmax_dp.sv
`default_nettype none
module rlmax_dp
  import rlmax_pkg::*;
#(
  parameter int SIZE = 1024
) (
  input  wire          clk,
  input  wire          rst_n,
  input  cmd_t         cmd,
  output sts_t         sts,
  input  wire          in_tvalid,
  input  wire  [103:0] in_tdata,
  input  wire          out_tready,
  output logic         out_tvalid,
  output logic [63:0]  out_tdata,
  output logic         out_tuser
);

  localparam int NODES = 4 * SIZE;
  localparam int AW    = $clog2(NODES);
  localparam int IW    = $clog2(SIZE + 1);
  localparam int LVL   = $clog2(SIZE);
  localparam int STK   = 2 * LVL + 4;
  localparam int SPW   = $clog2(STK + 1);
  localparam int SPI   = $clog2(STK);
  localparam int ENT   = 2 * LVL + 2;
  localparam int CW    = $clog2(ENT + 1);
  localparam int KI    = $clog2(ENT);

  // input fields
  logic [1:0]  f_action;
  logic [10:0] f_first, f_last, f_widx;
  val_t        f_value;
  assign f_action = in_tdata[1:0];
  assign f_first  = in_tdata[12:2];
  assign f_last   = in_tdata[23:13];
  assign f_widx   = in_tdata[34:24];
  assign f_value  = in_tdata[97:35];

  logic in_fire;
  assign in_fire = in_tvalid && cmd.in_ready;

  logic          f_bad, f_wok;
  logic [1:0]    act_r;
  logic [IW-1:0] ql_r, qr_r;
  val_t          val_r;
  logic          bad_r, wok_r;

  assign f_bad = (f_first == 11'd0) || (32'(f_last) > SIZE) || (f_first > f_last);
  assign f_wok = (f_widx != 11'd0) && (32'(f_widx) <= SIZE);

  // node store
  node_t         mem [NODES];
  node_t         rd_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  node_t         wr_data;
  logic [AW-1:0] clr_r;

  // walk stack
  logic [AW-1:0] stk_o   [STK];
  logic [IW-1:0] stk_l   [STK];
  logic [IW-1:0] stk_r   [STK];
  val_t          stk_acc [STK];
  logic          stk_pull[STK];
  logic [SPW-1:0] sp_r, spm1;
  logic          push_en;
  logic [AW-1:0] push_o;
  logic [IW-1:0] push_l, push_r;
  val_t          push_acc;
  logic          push_pull;

  // current frame
  logic [AW-1:0] cur_o;
  logic [IW-1:0] cur_l, cur_r;
  val_t          cur_acc;
  logic          cur_pull;
  val_t          m_r;
  node_t         a_r;

  logic [IW:0]   sum;
  logic [IW-1:0] mid, mid_p1;
  logic [AW-1:0] a_o, b_o;
  logic          leaf_a, leaf_b;
  cls_t          cls;

  // canonical node list and best-pick state
  logic [AW-1:0] ent_o   [ENT];
  logic [IW-1:0] ent_l   [ENT];
  logic [IW-1:0] ent_r   [ENT];
  val_t          ent_acc [ENT];
  val_t          ent_and [ENT];
  val_t          ent_pre [ENT];
  logic [CW-1:0] cnt_r;
  logic [KI-1:0] k_r;
  val_t          run_r, suf_r, bf_out_r, best_r;
  val_t          rec_and;

  val_t          and_a, and_b, uor_a, uor_b, gl, gr, acc_child;

  logic          out_valid_r, out_bad_r;
  val_t          out_ans_r;

  assign sum    = {1'b0, cur_l} + {1'b0, cur_r};
  assign mid    = sum[IW:1];
  assign mid_p1 = IW'({1'b0, mid} + 1'b1);
  assign a_o    = {cur_o[AW-2:0], 1'b0};
  assign b_o    = {cur_o[AW-2:0], 1'b1};
  assign leaf_a = (cur_l == mid);
  assign leaf_b = (mid_p1 == cur_r);
  assign spm1   = sp_r - 1'b1;
  assign acc_child = cur_acc & m_r;
  assign rec_and   = rd_r.andv & cur_acc;

  always_comb begin
    if (cur_pull)                               cls = CLS_PULL;
    else if ((qr_r < cur_l) || (cur_r < ql_r))  cls = CLS_DISJ;
    else if ((ql_r <= cur_l) && (cur_r <= qr_r)) cls = CLS_COV;
    else                                        cls = CLS_PART;
  end

  // greedy step of the descent inside one canonical node
  assign and_a = a_r.andv & cur_acc;
  assign and_b = rd_r.andv & cur_acc;
  assign uor_a = leaf_a ? ONES : (a_r.uor & cur_acc);
  assign uor_b = leaf_b ? ONES : (rd_r.uor & cur_acc);
  assign gl    = uor_a & and_b & bf_out_r;
  assign gr    = uor_b & and_a & bf_out_r;

  always_comb begin
    case (cmd.op)
      OP_EXAM:   rd_addr = (cls == CLS_PULL) ? a_o : cur_o;
      OP_PART_O: rd_addr = a_o;
      OP_PD_A:   rd_addr = b_o;
      OP_PULL_A: rd_addr = b_o;
      OP_BF_O:   rd_addr = a_o;
      OP_BF_A:   rd_addr = b_o;
      default:   rd_addr = cur_o;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_o;
    wr_data = apply_and(rd_r, cur_l == cur_r, val_r);
    case (cmd.op)
      OP_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '{pend: ONES, uor: ONES, andv: ONES};
      end
      OP_COV: begin
        wr_en = (act_r != ACT_QUERY);
        if (act_r == ACT_WRITE) begin
          wr_data = '{pend: ONES, uor: ONES, andv: val_r};
        end
      end
      OP_PD_A: begin
        wr_en   = 1'b1;
        wr_addr = a_o;
        wr_data = apply_and(rd_r, leaf_a, m_r);
      end
      OP_PD_B: begin
        wr_en   = 1'b1;
        wr_addr = b_o;
        wr_data = apply_and(rd_r, leaf_b, m_r);
      end
      OP_PULL_B: begin
        wr_en   = 1'b1;
        wr_data = pull_node(a_r, rd_r);
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[rd_addr];
  end

  always_comb begin
    push_en   = 1'b1;
    push_o    = AW'(1);
    push_l    = IW'(1);
    push_r    = IW'(SIZE);
    push_acc  = ONES;
    push_pull = 1'b0;
    case (cmd.op)
      OP_DECIDE: push_en = 1'b1;
      OP_PUSH_P: begin
        push_o    = cur_o;
        push_l    = cur_l;
        push_r    = cur_r;
        push_acc  = cur_acc;
        push_pull = 1'b1;
      end
      OP_PUSH_R: begin
        push_o   = b_o;
        push_l   = mid_p1;
        push_r   = cur_r;
        push_acc = acc_child;
      end
      OP_PUSH_L: begin
        push_o   = a_o;
        push_l   = cur_l;
        push_r   = mid;
        push_acc = acc_child;
      end
      default: push_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      stk_o[sp_r[SPI-1:0]]    <= push_o;
      stk_l[sp_r[SPI-1:0]]    <= push_l;
      stk_r[sp_r[SPI-1:0]]    <= push_r;
      stk_acc[sp_r[SPI-1:0]]  <= push_acc;
      stk_pull[sp_r[SPI-1:0]] <= push_pull;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      sp_r        <= '0;
      cnt_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_CLEAR) clr_r <= clr_r + 1'b1;
      if (cmd.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_DECIDE: begin
          // keep the stack empty when no walk follows, so the root lands in slot 0
          sp_r  <= sts.start_walk ? SPW'(1) : '0;
          cnt_r <= '0;
        end
        OP_POP: if (sp_r != '0) sp_r <= spm1;
        OP_PUSH_P, OP_PUSH_R, OP_PUSH_L: sp_r <= sp_r + 1'b1;
        OP_COV: if (act_r == ACT_QUERY) cnt_r <= cnt_r + 1'b1;
        OP_BF_INIT: k_r <= KI'(cnt_r - 1'b1);
        OP_BF_TEST: if ((cur_l == cur_r) && (k_r != '0)) k_r <= k_r - 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r <= f_action;
      bad_r <= f_bad;
      wok_r <= f_wok;
      val_r <= f_value;
      if (f_action == ACT_WRITE) begin
        ql_r <= IW'(f_widx);
        qr_r <= IW'(f_widx);
      end else begin
        ql_r <= IW'(f_first);
        qr_r <= IW'(f_last);
      end
    end
    if (cmd.op == OP_EMIT) begin
      out_ans_r <= best_r;
      out_bad_r <= bad_r;
    end
    case (cmd.op)
      OP_DECIDE: begin
        run_r  <= ONES;
        best_r <= '0;
      end
      OP_POP: begin
        cur_o    <= stk_o[spm1[SPI-1:0]];
        cur_l    <= stk_l[spm1[SPI-1:0]];
        cur_r    <= stk_r[spm1[SPI-1:0]];
        cur_acc  <= stk_acc[spm1[SPI-1:0]];
        cur_pull <= stk_pull[spm1[SPI-1:0]];
      end
      OP_COV: begin
        if (act_r == ACT_QUERY) begin
          ent_o[cnt_r[KI-1:0]]   <= cur_o;
          ent_l[cnt_r[KI-1:0]]   <= cur_l;
          ent_r[cnt_r[KI-1:0]]   <= cur_r;
          ent_acc[cnt_r[KI-1:0]] <= cur_acc;
          ent_and[cnt_r[KI-1:0]] <= rec_and;
          ent_pre[cnt_r[KI-1:0]] <= run_r;
          run_r <= run_r & rec_and;
        end
      end
      OP_PART_O: m_r <= rd_r.pend;
      OP_PULL_A: a_r <= rd_r;
      OP_BF_INIT: begin
        suf_r  <= ONES;
      end
      OP_BF_LOAD: begin
        cur_o    <= ent_o[k_r];
        cur_l    <= ent_l[k_r];
        cur_r    <= ent_r[k_r];
        cur_acc  <= ent_acc[k_r];
        bf_out_r <= ent_pre[k_r] & suf_r;
        suf_r    <= suf_r & ent_and[k_r];
      end
      OP_BF_TEST: begin
        if (cur_l == cur_r) best_r <= (bf_out_r > best_r) ? bf_out_r : best_r;
      end
      OP_BF_O: cur_acc <= cur_acc & rd_r.pend;
      OP_BF_A: a_r <= rd_r;
      OP_BF_B: begin
        if (gl > gr) begin
          bf_out_r <= bf_out_r & and_b;
          cur_o    <= a_o;
          cur_r    <= mid;
        end else begin
          bf_out_r <= bf_out_r & and_a;
          cur_o    <= b_o;
          cur_l    <= mid_p1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.clear_done  = (clr_r == AW'(NODES - 1));
    sts.in_fire     = in_fire;
    sts.is_query    = (act_r == ACT_QUERY);
    sts.start_walk  = ((act_r == ACT_UPDATE) && !bad_r) ||
                      ((act_r == ACT_WRITE) && wok_r) ||
                      ((act_r == ACT_QUERY) && !bad_r);
    sts.emit_bad    = (act_r == ACT_QUERY) && bad_r;
    sts.stack_empty = (sp_r == '0);
    sts.cls         = cls;
    sts.cur_leaf    = (cur_l == cur_r);
    sts.k_zero      = (k_r == '0);
    sts.out_free    = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_ans_r};
  assign out_tuser  = out_bad_r;

endmodule
`default_nettype wire

// File: sv/range_and_leave_one_out_max_top.sv
// Range-AND store with a leave-one-out maximum query.
// Input channel in_*: one beat per action. in_tdata from bit 0 up: action[1:0],
// first_index[12:2], last_index[23:13], write_index[34:24], operand_value[97:35],
// zero fill. Range AND updates and point writes give no beat out; a query
// gives one beat on out_*: out_tdata holds answer[62:0], out_tuser bad_range.
// After reset the block sweeps its node store to all ones, one node a cycle,
// and holds in_tready low until the sweep of all 4*SIZE nodes ends.
// One action is worked at a time; in_tready is high only between actions.
// An update or write walks the tree from the root with lazy masks, paced by
// the single read and write port of the node store. A query walks the tree
// to collect the covering nodes, then descends each one for the best element
// to leave out, one level per pass through BF_TEST, BF_O, BF_A and BF_B.
// A finished query result waits in an output register; if the receiver
// stalls, the next action is still taken, and only a further query result
// waits until that register frees.
`default_nettype none
module range_and_leave_one_out_max_top
  import rlmax_pkg::*;
#(
  parameter int SIZE = 1024
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [103:0] in_tdata,   // action, first_index, last_index, write_index, operand_value
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [63:0]  out_tdata,  // answer
  output logic         out_tuser   // bad_range
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: one state per step of the tree walk
  rlmax_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // node store, walk stack, node list and result register
  rlmax_dp #(
    .SIZE (SIZE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  assign in_tready = cmd.in_ready;

`ifndef SYNTH
  // a bad range always reports a zero answer
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == 64'd0))
    else $error("bad range beat carries a non-zero answer");

  // one action at a time: no second beat straight after an accepted one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted on two cycles in a row");

  // a result beat only appears after the sequencer emits it
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.op == OP_EMIT))
    else $error("result beat raised without an emit");

  a_emit_vis: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT) |=> out_tvalid)
    else $error("emitted result not shown");
`endif

endmodule
`default_nettype wire
